FILE: hdl/mfbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
package mfbp_pkg;

	// Input command codes
	localparam logic CMD_PUT   = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Widest field a put may write; larger counts saturate here
	localparam logic [5:0] FIELD_LIMIT = 6'd32;

	// Configuration space
	localparam int unsigned    CAP_W        = 17;
	localparam logic [16:0]    CAP_RESET    = 17'h10000;
	localparam int unsigned    ADDR_W       = 3;
	localparam logic           REG_CAPACITY = 1'b0;

	// Controller to datapath
	typedef struct packed {
		logic load;   // take the input transaction into the window
		logic emit;   // move the top byte of the window to the output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic load_emits; // the presented input transaction completes at least one byte
		logic last_byte;  // the byte at the top of the window is the final one
		logic out_free;   // output register can take a byte this cycle
	} dp_sts_t;

endpackage

FILE: hdl/mfbp_regs.sv
// APB register block holding the capacity register.
module mfbp_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mfbp_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output logic [mfbp_pkg::CAP_W-1:0]      capacity
);

	logic                           reg_sel;
	logic                           wr_en;
	logic [mfbp_pkg::CAP_W-1:0]     cap_q;

	assign reg_sel = (paddr[mfbp_pkg::ADDR_W-1] == mfbp_pkg::REG_CAPACITY);
	assign wr_en   = psel && penable && pwrite && pready && reg_sel;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= mfbp_pkg::CAP_RESET;
		end else if (wr_en) begin
			cap_q <= pwdata[mfbp_pkg::CAP_W-1:0];
		end
	end

	assign prdata   = reg_sel ? {{(32 - mfbp_pkg::CAP_W){1'b0}}, cap_q} : 32'd0;
	assign capacity = cap_q;

endmodule

FILE: hdl/mfbp_ctrl.sv
// Controller state machine: accepts a transaction, then steps out its bytes.
module mfbp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mfbp_pkg::dp_sts_t   sts,
	output mfbp_pkg::dp_cmd_t   cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_stall = (state_q != ST_IDLE);
	assign cmd.load = in_valid && (state_q == ST_IDLE);
	assign cmd.emit = (state_q == ST_EMIT) && sts.out_free;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.load && sts.load_emits) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (cmd.emit && sts.last_byte) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: hdl/mfbp_dp.sv
// Datapath: 40-bit packing window, byte position counter, output register.
module mfbp_dp #(
	parameter int unsigned MAX_BYTES = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mfbp_pkg::dp_cmd_t               cmd,
	output mfbp_pkg::dp_sts_t               sts,
	input  logic                            op,
	input  logic [31:0]                     bits,
	input  logic [5:0]                      bit_count,
	input  logic [mfbp_pkg::CAP_W-1:0]      capacity,
	input  logic                            out_stall,
	output logic                            out_valid,
	output logic [7:0]                      data_byte,
	output logic [15:0]                     byte_index,
	output logic                            overflow,
	output logic                            last
);

	localparam int unsigned PW = $clog2(MAX_BYTES + 1);
	localparam int unsigned CW = (PW > mfbp_pkg::CAP_W) ? PW : mfbp_pkg::CAP_W;

	logic [39:0]    win_q;      // pending bits left-aligned; low bits zero
	logic [5:0]     cnt_q;      // valid bits in the window
	logic           flush_q;
	logic [PW-1:0]  pos_q;

	logic [2:0]     pend;
	logic [5:0]     c_sat;
	logic [31:0]    fld;
	logic [39:0]    win_load;
	logic [5:0]     cnt_load;
	logic [CW-1:0]  cap_ext;
	logic [CW-1:0]  cap_eff;
	logic [CW-1:0]  pos_ext;
	logic [31:0]    pos_wide;
	logic           in_room;

	assign pend     = cnt_q[2:0];
	assign c_sat    = (bit_count > mfbp_pkg::FIELD_LIMIT) ? mfbp_pkg::FIELD_LIMIT : bit_count;
	// left-align the field; a zero count shifts everything out
	assign fld      = bits << (6'd32 - c_sat);
	assign win_load = {win_q[39:32], 32'd0} | ({fld, 8'd0} >> pend);
	assign cnt_load = {3'd0, pend} + c_sat;

	assign sts.load_emits = (op == mfbp_pkg::CMD_FLUSH) ? (pend != 3'd0) : (cnt_load >= 6'd8);
	assign sts.last_byte  = flush_q || (cnt_q < 6'd16);
	assign sts.out_free   = !out_valid || !out_stall;

	// capacity clamps at MAX_BYTES
	assign cap_ext  = CW'(capacity);
	assign cap_eff  = (cap_ext > CW'(MAX_BYTES)) ? CW'(MAX_BYTES) : cap_ext;
	assign pos_ext  = CW'(pos_q);
	assign in_room  = (pos_ext < cap_eff);
	assign pos_wide = 32'(pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q   <= 40'd0;
			cnt_q   <= 6'd0;
			flush_q <= 1'b0;
			pos_q   <= '0;
		end else if (cmd.load) begin
			if (op == mfbp_pkg::CMD_FLUSH) begin
				flush_q <= 1'b1;
			end else begin
				win_q   <= win_load;
				cnt_q   <= cnt_load;
				flush_q <= 1'b0;
			end
		end else if (cmd.emit) begin
			win_q   <= {win_q[31:0], 8'd0};
			cnt_q   <= flush_q ? 6'd0 : (cnt_q - 6'd8);
			flush_q <= 1'b0;
			if (in_room) pos_q <= pos_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			data_byte  <= win_q[39:32];
			byte_index <= in_room ? pos_wide[15:0] : 16'd0;
			overflow   <= !in_room;
			last       <= sts.last_byte;
		end
	end

endmodule

FILE: hdl/msb_first_bit_packer_top.sv
// A transaction is taken while idle; its first byte enters the output register from the emit state.
// Throughput: a put or flush that completes k bytes (k up to 4) stalls the input until its
//   last byte is emitted, one byte leaving the output register per cycle; k = 0 does not stall.
//   Output stalls stretch this, since the single output register gates each byte.
// Reset (arst_n low, asynchronous): pending bits and byte position clear, capacity = 65536.
// Top level of the MSB-first bit packer.
module msb_first_bit_packer_top #(
	parameter int unsigned MAX_BYTES = 65536
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [mfbp_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	// input transactions
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cmd,
	input  logic [31:0]                     bits,
	input  logic [5:0]                      bit_count,
	// output transactions, one per byte
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      data_byte,
	output logic [15:0]                     byte_index,
	output logic                            overflow,
	output logic                            last
);

	// capacity register, clamped to MAX_BYTES inside the datapath
	logic [mfbp_pkg::CAP_W-1:0] capacity;

	// command and status between controller and datapath
	mfbp_pkg::dp_cmd_t dp_cmd;
	mfbp_pkg::dp_sts_t dp_sts;

	mfbp_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.capacity (capacity)
	);

	// The controller accepts a transaction only when idle, then drives one
	// emit per free output slot until the last byte of that transaction.
	mfbp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// The datapath merges a put's field into a 40-bit window behind the pending
	// bits, then shifts one byte per emit into the output register.
	mfbp_dp #(
		.MAX_BYTES (MAX_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.op         (cmd),
		.bits       (bits),
		.bit_count  (bit_count),
		.capacity   (capacity),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.data_byte  (data_byte),
		.byte_index (byte_index),
		.overflow   (overflow),
		.last       (last)
	);

endmodule

FILE: hdl/mfbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
module mfbp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [7:0]                   data_byte,
	input logic [15:0]                  byte_index,
	input logic                         overflow,
	input logic                         last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) &&
		$stable(byte_index) && $stable(overflow) && $stable(last))
		else $error("stalled output transaction changed");

	// dropped bytes report index zero
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && overflow |-> byte_index == 16'd0)
		else $error("overflow byte with nonzero index");

	// no new input while the current transaction still has bytes to send
	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> in_stall)
		else $error("input taken before last byte of transaction");

	// bytes of one transaction follow back to back
	a_next_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside a multi-byte transaction");

endmodule

bind msb_first_bit_packer_top mfbp_checker u_mfbp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_byte  (data_byte),
	.byte_index (byte_index),
	.overflow   (overflow),
	.last       (last)
);
